// ===== design/aqc_pkg.sv =====
// ----------------------------------------------------------------------------
// aqc_pkg: shared types and codes of the alarm queue
// Item and result structs, table entry layout, kind and status codes, and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package aqc_pkg;

  // Default table depth.
  localparam int CAPACITY_DEF = 16;

  // Field widths.
  localparam int KIND_W   = 2;
  localparam int TIME_W   = 40;
  localparam int COOKIE_W = 32;
  localparam int TARGET_W = 8;
  localparam int STATUS_W = 3;

  // Item kinds.
  localparam logic [KIND_W-1:0] KIND_SCHEDULE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_CLEAR    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PAST        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOTHING_DUE = 3'd4;

  // One input item.
  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [TIME_W-1:0]   due_time;
    logic [COOKIE_W-1:0] cancel_cookie;
    logic [TIME_W-1:0]   now;
    logic [TARGET_W-1:0] target_handle;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COOKIE_W-1:0] out_cookie;
    logic [TARGET_W-1:0] fired_target;
    logic                fired;
    logic [TIME_W-1:0]   next_due;
    logic                armed;
  } out_item_t;

  // One alarm as held in the table memory.
  typedef struct packed {
    logic [TIME_W-1:0]   due;
    logic [COOKIE_W-1:0] cookie;
    logic [TARGET_W-1:0] target;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // Datapath commands, one per cycle.
  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_SCHED_PAST,
    OP_SCHED_FULL,
    OP_SCHED_START,
    OP_INS_READ,
    OP_INS_MOVE,
    OP_INS_PLACE_UP,
    OP_INS_PLACE_LOW,
    OP_CMP_START,
    OP_TICK_FIRE,
    OP_TICK_IDLE,
    OP_CMP_READ,
    OP_CMP_STEP,
    OP_CMP_LAST,
    OP_FINISH
  } dp_op_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              past;
    logic              full;
    logic              empty;
    logic              due_now;
    logic              later;
    logic              idx_zero;
    logic              last;
    logic              out_free;
  } dp_stat_t;

endpackage

// ===== design/aqc_ram.sv =====
// ----------------------------------------------------------------------------
// aqc_ram: generic single-port-write RAM with registered read
// One write port and one read port; read data appears in the cycle after the
// read enable.
// ----------------------------------------------------------------------------
module aqc_ram
  import aqc_pkg::*;
#(
  parameter int WIDTH  = ENTRY_W,
  parameter int DEPTH  = CAPACITY_DEF,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== design/aqc_ctrl.sv =====
// ----------------------------------------------------------------------------
// aqc_ctrl: sequencer of the alarm queue
// Decodes each item and steps the datapath through the insertion walk or
// the compaction walk, then hands the result to the output register.
// ----------------------------------------------------------------------------
module aqc_ctrl
  import aqc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  dp_stat_t stat,
  output dp_op_t   op
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_INS_RD,
    S_INS_CHK,
    S_PLACE_LOW,
    S_CMP_RD,
    S_CMP_CHK,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  // A new item is taken only between items.
  assign in_stall = (state_r != S_IDLE);

  // Next state and command.
  always_comb begin
    state_nxt = state_r;
    op        = OP_NONE;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          op        = OP_LOAD;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (stat.kind)
          KIND_SCHEDULE: begin
            if (stat.past) begin
              op        = OP_SCHED_PAST;
              state_nxt = S_FINISH;
            end else if (stat.full) begin
              op        = OP_SCHED_FULL;
              state_nxt = S_FINISH;
            end else begin
              op        = OP_SCHED_START;
              state_nxt = stat.empty ? S_PLACE_LOW : S_INS_RD;
            end
          end
          KIND_CLEAR: begin
            if (stat.empty) begin
              state_nxt = S_FINISH;
            end else begin
              op        = OP_CMP_START;
              state_nxt = S_CMP_RD;
            end
          end
          KIND_TICK: begin
            if (!stat.empty && stat.due_now) begin
              op        = OP_TICK_FIRE;
              state_nxt = S_CMP_RD;
            end else begin
              op        = OP_TICK_IDLE;
              state_nxt = S_FINISH;
            end
          end
          default: begin
            state_nxt = S_FINISH;
          end
        endcase
      end
      S_INS_RD: begin
        op        = OP_INS_READ;
        state_nxt = S_INS_CHK;
      end
      S_INS_CHK: begin
        // Later alarms move up one place; the new one lands above the
        // first alarm that is not later than it.
        if (stat.later) begin
          op        = OP_INS_MOVE;
          state_nxt = stat.idx_zero ? S_PLACE_LOW : S_INS_RD;
        end else begin
          op        = OP_INS_PLACE_UP;
          state_nxt = S_FINISH;
        end
      end
      S_PLACE_LOW: begin
        op        = OP_INS_PLACE_LOW;
        state_nxt = S_FINISH;
      end
      S_CMP_RD: begin
        op        = OP_CMP_READ;
        state_nxt = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (stat.last) begin
          op        = OP_CMP_LAST;
          state_nxt = S_FINISH;
        end else begin
          op        = OP_CMP_STEP;
          state_nxt = S_CMP_RD;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          op        = OP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== design/aqc_dp.sv =====
// ----------------------------------------------------------------------------
// aqc_dp: datapath of the alarm queue
// Holds the item, the alarm count, the cookie counter, a copy of the
// earliest alarm, the walk indexes, the result and the output register,
// and drives the table memory.
// ----------------------------------------------------------------------------
module aqc_dp
  import aqc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  dp_op_t    op,
  output dp_stat_t  stat,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  in_item_t            item_r,       item_nxt;
  logic [CNT_W-1:0]    count_r,      count_nxt;
  logic [COOKIE_W-1:0] ctr_r,        ctr_nxt;
  entry_t              front_r,      front_nxt;
  logic [IDX_W-1:0]    idx_r,        idx_nxt;
  logic [IDX_W-1:0]    ri_r,         ri_nxt;
  logic [CNT_W-1:0]    wi_r,         wi_nxt;
  logic                drop_front_r, drop_front_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [COOKIE_W-1:0] res_cookie_r, res_cookie_nxt;
  logic [TARGET_W-1:0] res_target_r, res_target_nxt;
  logic                res_fired_r,  res_fired_nxt;
  logic                out_valid_r,  out_valid_nxt;
  out_item_t           out_data_r,   out_data_nxt;

  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  entry_t           new_entry;
  logic             keep;
  logic [CNT_W-1:0] wi_plus;
  logic [CNT_W-1:0] count_m1;

  aqc_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The alarm being scheduled takes the latest issued cookie.
  assign new_entry = '{due: item_r.due_time, cookie: ctr_r, target: item_r.target_handle};

  // In the compaction walk a tick drops the first alarm only, a clear
  // drops every alarm with a matching cookie.
  assign keep     = drop_front_r ? (ri_r != '0) : (ram_rdata.cookie != item_r.cancel_cookie);
  assign wi_plus  = wi_r + CNT_W'(keep);
  assign count_m1 = count_r - CNT_W'(1);

  // Status towards the controller.
  always_comb begin
    stat.kind     = item_r.kind;
    stat.past     = (item_r.due_time < item_r.now);
    stat.full     = (count_r == CNT_W'(CAPACITY));
    stat.empty    = (count_r == '0);
    stat.due_now  = (front_r.due <= item_r.now);
    stat.later    = (ram_rdata.due > item_r.due_time);
    stat.idx_zero = (idx_r == '0);
    stat.last     = (ri_r == count_m1[IDX_W-1:0]);
    stat.out_free = !out_valid_r || !out_stall;
  end

  // Command execution.
  always_comb begin
    item_nxt       = item_r;
    count_nxt      = count_r;
    ctr_nxt        = ctr_r;
    front_nxt      = front_r;
    idx_nxt        = idx_r;
    ri_nxt         = ri_r;
    wi_nxt         = wi_r;
    drop_front_nxt = drop_front_r;
    res_status_nxt = res_status_r;
    res_cookie_nxt = res_cookie_r;
    res_target_nxt = res_target_r;
    res_fired_nxt  = res_fired_r;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_waddr      = '0;
    ram_wdata      = new_entry;
    ram_re         = 1'b0;
    ram_raddr      = idx_r;

    // A waiting result leaves once the far side takes it.
    out_valid_nxt = out_valid_r && out_stall;

    unique case (op)
      OP_LOAD: begin
        item_nxt       = in_data;
        res_status_nxt = ST_OK;
        res_cookie_nxt = '0;
        res_target_nxt = '0;
        res_fired_nxt  = 1'b0;
      end
      OP_SCHED_PAST: begin
        ctr_nxt        = ctr_r + COOKIE_W'(1);
        res_status_nxt = ST_PAST;
      end
      OP_SCHED_FULL: begin
        ctr_nxt        = ctr_r + COOKIE_W'(1);
        res_status_nxt = ST_FULL;
      end
      OP_SCHED_START: begin
        ctr_nxt        = ctr_r + COOKIE_W'(1);
        res_cookie_nxt = ctr_r + COOKIE_W'(1);
        idx_nxt        = count_m1[IDX_W-1:0];
      end
      OP_INS_READ: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
      end
      OP_INS_MOVE: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + IDX_W'(1);
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r - IDX_W'(1);
      end
      OP_INS_PLACE_UP: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r + IDX_W'(1);
        count_nxt = count_r + CNT_W'(1);
      end
      OP_INS_PLACE_LOW: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        count_nxt = count_r + CNT_W'(1);
      end
      OP_CMP_START: begin
        ri_nxt         = '0;
        wi_nxt         = '0;
        drop_front_nxt = 1'b0;
      end
      OP_TICK_FIRE: begin
        res_cookie_nxt = front_r.cookie;
        res_target_nxt = front_r.target;
        res_fired_nxt  = 1'b1;
        ri_nxt         = '0;
        wi_nxt         = '0;
        drop_front_nxt = 1'b1;
      end
      OP_TICK_IDLE: begin
        res_status_nxt = ST_NOTHING_DUE;
      end
      OP_CMP_READ: begin
        ram_re    = 1'b1;
        ram_raddr = ri_r;
      end
      OP_CMP_STEP, OP_CMP_LAST: begin
        if (keep) begin
          ram_we    = 1'b1;
          ram_waddr = wi_r[IDX_W-1:0];
          ram_wdata = ram_rdata;
        end
        wi_nxt = wi_plus;
        ri_nxt = ri_r + IDX_W'(1);
        if (op == OP_CMP_LAST) begin
          count_nxt = wi_plus;
          if (!drop_front_r && (wi_plus == count_r)) begin
            res_status_nxt = ST_NOT_FOUND;
          end
        end
      end
      OP_FINISH: begin
        out_valid_nxt             = 1'b1;
        out_data_nxt.status       = res_status_r;
        out_data_nxt.out_cookie   = res_cookie_r;
        out_data_nxt.fired_target = res_target_r;
        out_data_nxt.fired        = res_fired_r;
        out_data_nxt.next_due     = (count_r != '0) ? front_r.due : '0;
        out_data_nxt.armed        = (count_r != '0);
      end
      default: begin
      end
    endcase

    // Keep a copy of whatever lands at the head of the table.
    if (ram_we && (ram_waddr == '0)) begin
      front_nxt = ram_wdata;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ctr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      ctr_r       <= ctr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    front_r      <= front_nxt;
    idx_r        <= idx_nxt;
    ri_r         <= ri_nxt;
    wi_r         <= wi_nxt;
    drop_front_r <= drop_front_nxt;
    res_status_r <= res_status_nxt;
    res_cookie_r <= res_cookie_nxt;
    res_target_r <= res_target_nxt;
    res_fired_r  <= res_fired_nxt;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== design/alarm_queue_with_cookies.sv =====
// ----------------------------------------------------------------------------
// alarm_queue_with_cookies: sorted alarm table with cookies
// Schedules, clears and fires alarms kept in due-time order in one RAM.
// ----------------------------------------------------------------------------
// The block takes one item at a time and gives exactly one result for it.
// Items are held off (in_stall high) from the cycle after a transfer until
// the result has been placed in the output register; a result that waits
// there does not hold off the next item. The table sits in one RAM with a
// registered read, and every pass over it reads each alarm touched and then
// checks or moves it: a schedule walks down from the latest pending alarm
// until it meets one that is not later than the new one; a clear, and a
// tick that fires, pass over every pending alarm; a refused schedule, an
// empty clear, a tick with nothing due and an unused kind make no pass.
// The earliest alarm is mirrored in registers, so no pass is needed to
// judge a tick or to report the next due time.
module alarm_queue_with_cookies
  import aqc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  dp_op_t   op;
  dp_stat_t stat;

  // Sequencer.
  aqc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .op       (op)
  );

  // Table, counters and result registers.
  aqc_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .op        (op),
    .stat      (stat),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`ifndef ASSERT_OFF
  // An item in transfer always makes the block busy in the next cycle.
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after an item transfer");

  // A new result only appears at the end of the work on an item.
  a_result_after_work : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item at work");

  // A fired alarm is always reported as a success.
  a_fired_ok : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.fired) |-> (out_data.status == ST_OK))
    else $error("fired alarm with a failure status");

  // The result command is only given while the output register is free.
  a_finish_free : assert property (@(posedge clk) disable iff (!rst_n)
    (op == OP_FINISH) |-> (!out_valid || !out_stall))
    else $error("result overwrote a waiting result");
`endif

endmodule
